// ===== rtl/core/bitcrush_pitch_shifter_unit_defines.svh =====
// assertion macros for the bitcrush pitch shifter
// used by modules that carry concurrent checks; no other dependencies
`ifndef BITCRUSH_PITCH_SHIFTER_UNIT_DEFINES_SVH
`define BITCRUSH_PITCH_SHIFTER_UNIT_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define BCPS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BCPS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/bcps_pkg.sv =====
// shared constants and types for the bitcrush pitch shifter
// no dependencies
`timescale 1ns / 1ps

package bcps_pkg;

   localparam int SampleBits   = 12;
   localparam int FracBits     = 16;
   localparam int StoreDepth   = 512;   // power of two, pointers wrap naturally
   localparam int AddrBits     = $clog2(StoreDepth);
   localparam int PosBits      = AddrBits + FracBits;
   localparam int CrushBits    = 5;
   localparam int RateBits     = 18;
   localparam int CsrDataBits  = 18;
   localparam int CsrIndexBits = 1;
   localparam int ProdBits     = SampleBits + FracBits + 2;
   localparam int FifoDepth    = 4;
   localparam int FifoPtrBits  = $clog2(FifoDepth);
   localparam int FifoCntBits  = FifoPtrBits + 1;

   localparam logic [CrushBits-1:0] CrushReset = CrushBits'(1);
   localparam logic [RateBits-1:0]  RateReset  = RateBits'(65536);

   typedef enum logic [CsrIndexBits-1:0] {
      CsrCrushFactor = 1'b0,
      CsrPitchRate   = 1'b1
   } csr_index_type;

   // how each of the two interpolation taps gets its data
   typedef struct packed {
      logic                  valid;
      logic                  fwd_a;
      logic                  fwd_b;
      logic                  live_a;
      logic                  live_b;
      logic [SampleBits-1:0] fwd_data;
      logic [FracBits-1:0]   frac;
   } tap_ctrl_type;

endpackage

// ===== rtl/core/bcps_ram.sv =====
// generic ram: one write port, one read port with registered read data
// no dependencies
`timescale 1ns / 1ps

module bcps_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bcps_interp.sv =====
// two-stage linear interpolation between adjacent store entries
// depends on bcps_pkg
`timescale 1ns / 1ps

module bcps_interp (
   input  logic                                clock,
   input  logic                                reset,
   input  bcps_pkg::tap_ctrl_type              ctrl,
   input  logic [bcps_pkg::SampleBits-1:0]     ram_a,
   input  logic [bcps_pkg::SampleBits-1:0]     ram_b,
   output logic                                out_valid,
   output logic [bcps_pkg::SampleBits-1:0]     out_sample
);

   localparam int SB = bcps_pkg::SampleBits;
   localparam int FB = bcps_pkg::FracBits;
   localparam int PB = bcps_pkg::ProdBits;

   logic [SB-1:0]        tap_a;
   logic [SB-1:0]        tap_b;
   logic signed [SB:0]   diff;
   logic signed [PB-1:0] prod_in;
   logic signed [PB-1:0] prod_ff;
   logic [SB-1:0]        base_in;
   logic [SB-1:0]        base_ff;
   logic                 valid_in;
   logic                 valid_ff;
   logic signed [PB-1:0] mix;

   // unwritten entries read as zero, same-cycle writes are forwarded
   always_comb begin
      tap_a = ctrl.fwd_a ? ctrl.fwd_data : (ctrl.live_a ? ram_a : '0);
      tap_b = ctrl.fwd_b ? ctrl.fwd_data : (ctrl.live_b ? ram_b : '0);
      diff  = $signed({1'b0, tap_b}) - $signed({1'b0, tap_a});
   end

   // a*(1-f) + b*f folded into a + (b-a)*f, one multiplier
   assign prod_in  = PB'(diff * $signed({1'b0, ctrl.frac}));
   assign base_in  = tap_a;
   assign valid_in = ctrl.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      base_ff <= base_in;
   end

   assign mix = $signed({2'b00, base_ff, {FB{1'b0}}}) + prod_ff;

   always_comb begin
      if (mix[PB-1]) begin
         out_sample = '0;
      end else if (|mix[PB-2:FB+SB]) begin
         out_sample = '1;
      end else begin
         out_sample = mix[FB +: SB];
      end
   end

   assign out_valid = valid_ff;

endmodule

// ===== rtl/core/bitcrush_pitch_shifter_unit.sv =====
// Bitcrush pitch shifter: sample-and-hold decimation into a 512-entry ring
// store, read back at a fractional varispeed position with linear
// interpolation. Takes one item per clock cycle sustained while req_stall
// is low; each item's result passes the registered store read and the
// interpolation product register before it enters the output queue. The
// rate is set by the store access: every accepted item writes one entry and
// reads two, served by two copies of the store that are written alike, and
// a write and read of the same entry in one cycle is forwarded. The store
// needs no clearing pass after reset: entries are written in pointer order,
// so a wrap flag and the write pointer tell which entries still read as
// zero. req_stall rises when the four-entry output queue plus items in
// flight would be full. Configuration writes take effect for the next item.
// depends on bcps_pkg, bcps_ram, bcps_interp and the defines header
`timescale 1ns / 1ps
`include "bitcrush_pitch_shifter_unit_defines.svh"

module bitcrush_pitch_shifter_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [bcps_pkg::SampleBits-1:0]        req_sample_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [bcps_pkg::SampleBits-1:0]        rsp_sample_out,
   input  logic                                   csr_write_enable,
   input  bcps_pkg::csr_index_type                csr_index,
   input  logic [bcps_pkg::CsrDataBits-1:0]       csr_write_data
);

   localparam int SB = bcps_pkg::SampleBits;
   localparam int FB = bcps_pkg::FracBits;
   localparam int AB = bcps_pkg::AddrBits;
   localparam int PSB = bcps_pkg::PosBits;
   localparam int CB = bcps_pkg::CrushBits;
   localparam int RB = bcps_pkg::RateBits;
   localparam int QP = bcps_pkg::FifoPtrBits;
   localparam int QC = bcps_pkg::FifoCntBits;
   localparam int QD = bcps_pkg::FifoDepth;

   logic [CB-1:0]  crush_ff;
   logic [RB-1:0]  rate_ff;
   logic [CB-1:0]  hold_ff;
   logic [CB-1:0]  hold_in;
   logic [SB-1:0]  held_ff;
   logic [SB-1:0]  held_in;
   logic [AB-1:0]  wptr_ff;
   logic [AB-1:0]  wptr_in;
   logic           wrapped_ff;
   logic           wrapped_in;
   logic [PSB-1:0] rpos_ff;
   logic [PSB-1:0] rpos_in;
   logic [CB:0]    hold_sum;
   logic [AB-1:0]  idx_a;
   logic [AB-1:0]  idx_b;
   logic           accept;
   bcps_pkg::tap_ctrl_type ctrl_in;
   bcps_pkg::tap_ctrl_type ctrl_ff;
   logic [SB-1:0]  ram_a;
   logic [SB-1:0]  ram_b;
   logic           mix_valid;
   logic [SB-1:0]  mix_sample;

   logic [SB-1:0]  queue_ff [bcps_pkg::FifoDepth];
   logic [QP-1:0]  qwr_ff;
   logic [QP-1:0]  qrd_ff;
   logic [QC-1:0]  qcount_ff;
   logic [QC-1:0]  qcount_in;
   logic [QC-1:0]  in_flight;
   logic           pop;

   assign accept = req_valid && !req_stall;
   assign pop    = rsp_valid && !rsp_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         crush_ff <= bcps_pkg::CrushReset;
         rate_ff  <= bcps_pkg::RateReset;
      end else if (csr_write_enable) begin
         case (csr_index)
            bcps_pkg::CsrCrushFactor: crush_ff <= csr_write_data[CB-1:0];
            bcps_pkg::CsrPitchRate:   rate_ff  <= csr_write_data[RB-1:0];
            default: ;
         endcase
      end
   end

   // per-item state update
   always_comb begin
      hold_sum = {1'b0, hold_ff} + (CB+1)'(1);
      if (hold_sum >= {1'b0, crush_ff}) begin
         hold_in = '0;
         held_in = req_sample_in;
      end else begin
         hold_in = hold_sum[CB-1:0];
         held_in = held_ff;
      end
      wptr_in    = wptr_ff + AB'(1);
      wrapped_in = wrapped_ff || (wptr_ff == '1);
      rpos_in    = rpos_ff + PSB'(rate_ff);
      idx_a      = rpos_in[FB +: AB];
      idx_b      = idx_a + AB'(1);
   end

   // tap selection: forward the entry written this cycle, else the store
   // if the entry was written before, else zero
   always_comb begin
      ctrl_in.valid    = accept;
      ctrl_in.fwd_a    = (idx_a == wptr_ff);
      ctrl_in.fwd_b    = (idx_b == wptr_ff);
      ctrl_in.live_a   = wrapped_ff || (idx_a < wptr_ff);
      ctrl_in.live_b   = wrapped_ff || (idx_b < wptr_ff);
      ctrl_in.fwd_data = held_in;
      ctrl_in.frac     = rpos_in[FB-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff    <= '0;
         held_ff    <= '0;
         wptr_ff    <= '0;
         wrapped_ff <= 1'b0;
         rpos_ff    <= '0;
      end else if (accept) begin
         hold_ff    <= hold_in;
         held_ff    <= held_in;
         wptr_ff    <= wptr_in;
         wrapped_ff <= wrapped_in;
         rpos_ff    <= rpos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
      ctrl_ff.fwd_a    <= ctrl_in.fwd_a;
      ctrl_ff.fwd_b    <= ctrl_in.fwd_b;
      ctrl_ff.live_a   <= ctrl_in.live_a;
      ctrl_ff.live_b   <= ctrl_in.live_b;
      ctrl_ff.fwd_data <= ctrl_in.fwd_data;
      ctrl_ff.frac     <= ctrl_in.frac;
   end

   // two copies of the ring store, one per interpolation tap
   bcps_ram #(
      .WIDTH (SB),
      .DEPTH (bcps_pkg::StoreDepth)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wptr_ff),
      .wr_data (held_in),
      .rd_en   (accept),
      .rd_addr (idx_a),
      .rd_data (ram_a)
   );

   bcps_ram #(
      .WIDTH (SB),
      .DEPTH (bcps_pkg::StoreDepth)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wptr_ff),
      .wr_data (held_in),
      .rd_en   (accept),
      .rd_addr (idx_b),
      .rd_data (ram_b)
   );

   bcps_interp u_interp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl_ff),
      .ram_a      (ram_a),
      .ram_b      (ram_b),
      .out_valid  (mix_valid),
      .out_sample (mix_sample)
   );

   // output queue; items in flight hold a reserved slot
   assign in_flight = QC'(ctrl_ff.valid) + QC'(mix_valid) + qcount_ff;
   assign req_stall = (in_flight >= QC'(QD));

   always_comb begin
      qcount_in = qcount_ff;
      if (mix_valid && !pop) begin
         qcount_in = qcount_ff + QC'(1);
      end else if (!mix_valid && pop) begin
         qcount_in = qcount_ff - QC'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qwr_ff    <= '0;
         qrd_ff    <= '0;
         qcount_ff <= '0;
      end else begin
         qcount_ff <= qcount_in;
         if (mix_valid) begin
            qwr_ff <= qwr_ff + QP'(1);
         end
         if (pop) begin
            qrd_ff <= qrd_ff + QP'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mix_valid) begin
         queue_ff[qwr_ff] <= mix_sample;
      end
   end

   assign rsp_valid      = (qcount_ff != '0);
   assign rsp_sample_out = queue_ff[qrd_ff];

   `BCPS_ASSERT(a_slots_bounded, in_flight <= QC'(QD), "items in flight exceed queue")
   `BCPS_ASSERT(a_no_overflow, !(mix_valid && !pop && qcount_ff == QC'(QD)), "queue overflow")
   `BCPS_ASSERT_NEXT(a_wptr_step, accept, wptr_ff == $past(wptr_ff) + AB'(1), "wptr stuck")
   `BCPS_ASSERT_NEXT(a_pipe_order, ctrl_ff.valid, mix_valid, "interpolation lost an item")

endmodule

// ===== bench/bitcrush_pitch_shifter_checker.sv =====
// result checker for the bitcrush pitch shifter: watches the item channels and csr port
// keeps its own hold, ring store and read position state; depends on bcps_pkg
`timescale 1ns / 1ps

module bitcrush_pitch_shifter_checker
   import bcps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [SampleBits-1:0] req_sample_in,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [SampleBits-1:0] rsp_sample_out,
   input  logic                  csr_write_enable,
   input  csr_index_type         csr_index,
   input  logic [CsrDataBits-1:0] csr_write_data,
   output int                    pending_count,
   output int                    mismatch_count
);

   localparam logic [63:0] SampleMax = (64'd1 << SampleBits) - 64'd1;

   logic [CrushBits-1:0]  crush_setting = CrushReset;
   logic [RateBits-1:0]   rate_setting  = RateReset;
   logic [CrushBits-1:0]  hold_ticks    = '0;
   logic [SampleBits-1:0] held_value    = '0;
   logic [SampleBits-1:0] delay_line [StoreDepth];
   logic [AddrBits-1:0]   write_ptr     = '0;
   logic [PosBits-1:0]    read_pos      = '0;

   logic [SampleBits-1:0] expected_samples [$];
   logic [SampleBits-1:0] want_sample;
   int                    errors = 0;

   initial begin
      pending_count  = 0;
      mismatch_count = 0;
      for (int k = 0; k < StoreDepth; k++) delay_line[k] = '0;
   end

   // one tick of sample-and-hold, ring write and interpolated read
   function automatic logic [SampleBits-1:0] shift_sample(input logic [SampleBits-1:0] sample);
      logic [CrushBits:0]    count_next;
      logic [AddrBits-1:0]   tap0;
      logic [AddrBits-1:0]   tap1;
      logic [FracBits-1:0]   frac;
      logic [63:0]           mix;
      count_next = {1'b0, hold_ticks} + 1'b1;
      // crush factor zero behaves like one: every tick takes the sample
      if (count_next >= {1'b0, crush_setting}) begin
         hold_ticks = '0;
         held_value = sample;
      end else begin
         hold_ticks = count_next[CrushBits-1:0];
      end
      delay_line[write_ptr] = held_value;
      write_ptr = write_ptr + 1'b1;
      // position wraps at the store span by width
      read_pos = read_pos + PosBits'(rate_setting);
      tap0 = read_pos[PosBits-1:FracBits];
      tap1 = tap0 + 1'b1;
      frac = read_pos[FracBits-1:0];
      mix = (64'(delay_line[tap0]) * ((64'd1 << FracBits) - 64'(frac))
             + 64'(delay_line[tap1]) * 64'(frac)) >> FracBits;
      if (mix > SampleMax) mix = SampleMax;
      return mix[SampleBits-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         crush_setting = CrushReset;
         rate_setting  = RateReset;
         hold_ticks    = '0;
         held_value    = '0;
         write_ptr     = '0;
         read_pos      = '0;
         for (int k = 0; k < StoreDepth; k++) delay_line[k] = '0;
         expected_samples.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CsrCrushFactor: crush_setting = csr_write_data[CrushBits-1:0];
               CsrPitchRate:   rate_setting  = csr_write_data[RateBits-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_samples.push_back(shift_sample(req_sample_in));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: sample_out with no item pending: expected none, actual %0d",
                        $time, rsp_sample_out);
               errors++;
            end else begin
               want_sample = expected_samples.pop_front();
               if (rsp_sample_out !== want_sample) begin
                  $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                           $time, want_sample, rsp_sample_out);
                  errors++;
               end
            end
         end
      end
      pending_count  <= expected_samples.size();
      mismatch_count <= errors;
   end

endmodule

// ===== bench/tb_bitcrush_pitch_shifter_unit.sv =====
// top of the bitcrush pitch shifter testbench: clock, reset, stimulus and verdict
// depends on bcps_pkg, bitcrush_pitch_shifter_unit and bitcrush_pitch_shifter_checker
`timescale 1ns / 1ps

module tb_bitcrush_pitch_shifter_unit;
   import bcps_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int ItemCount  = 1150;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic [SampleBits-1:0]  req_sample_in    = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic [SampleBits-1:0]  rsp_sample_out;
   logic                   csr_write_enable = 1'b0;
   csr_index_type          csr_index        = CsrCrushFactor;
   logic [CsrDataBits-1:0] csr_write_data   = '0;

   logic tx_quiet      = 1'b0;
   logic rsp_quiet     = 1'b0;
   int   rsp_hold_left = 0;
   int   pending_count;
   int   mismatch_count;
   int   samples_sent  = 0;
   int   phase_count   = 0;
   int   cycle_count   = 0;

   always #4 clock = ~clock;

   bitcrush_pitch_shifter_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_in    (req_sample_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_out   (rsp_sample_out),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   bitcrush_pitch_shifter_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_in    (req_sample_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_out   (rsp_sample_out),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .pending_count    (pending_count),
      .mismatch_count   (mismatch_count)
   );

   // output side: after each taken item, stall for a drawn number of cycles
   always @(posedge clock) begin : rsp_pacing
      int next_hold;
      if (reset) begin
         next_hold = 0;
      end else if (rsp_valid && !rsp_stall) begin
         next_hold = rsp_quiet ? 0 : $urandom_range(0, 10);
      end else if (rsp_hold_left > 0) begin
         next_hold = rsp_hold_left - 1;
      end else begin
         next_hold = 0;
      end
      rsp_hold_left <= next_hold;
      rsp_stall     <= (next_hold != 0);
   end

   // called at a rising edge; returns at the edge the item is taken
   task automatic send_sample(input logic [SampleBits-1:0] sample);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= sample;
      do @(posedge clock); while (req_stall);
      samples_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_config(input logic [CsrDataBits-1:0] crush_data,
                               input logic [CsrDataBits-1:0] rate_data);
      csr_write_enable <= 1'b1;
      csr_index        <= CsrCrushFactor;
      csr_write_data   <= crush_data;
      @(posedge clock);
      csr_index        <= CsrPitchRate;
      csr_write_data   <= rate_data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      phase_count++;
   endtask

   initial begin : watchdog
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d items still pending", cycle_count, pending_count);
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      logic [SampleBits-1:0]  sample;
      logic [CsrDataBits-1:0] crush_data;
      logic [CsrDataBits-1:0] rate_data;
      int                     phase_len;
      logic                   quiet;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: no crush, unity pitch
      send_sample(12'd0);
      send_sample(12'd4095);
      send_sample(12'd1);
      send_sample(12'd4094);
      send_sample(12'h800);
      send_sample(12'h7FF);
      send_sample(12'hAAA);
      send_sample(12'h555);
      // crush zero with high data bits masked, pitch frozen
      wait_drained();
      write_config(18'h3FFE0, 18'd0);
      send_sample(12'd4095);
      send_sample(12'd0);
      send_sample(12'h123);
      send_sample(12'hFED);
      // longest hold, largest step
      wait_drained();
      write_config(18'h0001F, 18'h3FFFF);
      send_sample(12'd4095);
      send_sample(12'd4095);
      send_sample(12'd0);
      send_sample(12'hC3C);
      // hold of twenty, double speed
      wait_drained();
      write_config({13'h1555, 5'd20}, 18'd131072);
      send_sample(12'd2048);
      send_sample(12'd4095);
      send_sample(12'd0);
      send_sample(12'd1000);
      // no crush, smallest nonzero step
      wait_drained();
      write_config({13'h0AAA, 5'd1}, 18'd1);
      send_sample(12'd4095);
      send_sample(12'd4095);
      send_sample(12'd17);
      send_sample(12'd3000);

      while (samples_sent < ItemCount) begin
         wait_drained();
         crush_data = CsrDataBits'($urandom());
         case ($urandom_range(0, 7))
            0:       crush_data[CrushBits-1:0] = 5'd0;
            1:       crush_data[CrushBits-1:0] = 5'd1;
            2:       crush_data[CrushBits-1:0] = 5'd20;
            3:       crush_data[CrushBits-1:0] = 5'd31;
            default: crush_data[CrushBits-1:0] = CrushBits'($urandom_range(1, 20));
         endcase
         case ($urandom_range(0, 7))
            0:       rate_data = 18'd0;
            1:       rate_data = 18'd65536;
            2:       rate_data = 18'd131072;
            3:       rate_data = 18'h3FFFF;
            4:       rate_data = CsrDataBits'($urandom_range(0, 262143));
            5:       rate_data = CsrDataBits'($urandom_range(60000, 71000));
            default: rate_data = CsrDataBits'($urandom_range(0, 131072));
         endcase
         write_config(crush_data, rate_data);
         quiet     = ($urandom_range(0, 3) == 0);
         tx_quiet  = quiet;
         rsp_quiet <= quiet;
         phase_len = $urandom_range(30, 120);
         if (phase_len > ItemCount - samples_sent) begin
            phase_len = ItemCount - samples_sent;
         end
         repeat (phase_len) begin
            case ($urandom_range(0, 9))
               0:       sample = '0;
               1:       sample = '1;
               default: sample = SampleBits'($urandom_range(0, 4095));
            endcase
            send_sample(sample);
         end
      end

      tx_quiet = 1'b0;
      wait_drained();
      repeat (8) @(posedge clock);
      $display("covered %0d samples over %0d csr phases after the reset settings",
               samples_sent, phase_count);
      $display("crush factors 0 to 31, pitch steps 0 to 262143, random gaps and output stalls");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
